### rtl/core/byte_budget_lru_table_top_macros.svh
// Assertion macros for the table checker
`ifndef BYTE_BUDGET_LRU_TABLE_TOP_MACROS_SVH
`define BYTE_BUDGET_LRU_TABLE_TOP_MACROS_SVH
// implication checked every clock, off during reset
`define BBL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define BBL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### rtl/core/bbl_pkg.sv
package bbl_pkg;
    localparam int unsigned TableEntriesDefault = 32;
    localparam int unsigned KeyW   = 64;
    localparam int unsigned SizeW  = 32;
    localparam int unsigned TotalW = 48;
    localparam int unsigned StampW = 64;
    localparam int unsigned CmdQDepth = 2;

    localparam logic [1:0] ActStore   = 2'd0;
    localparam logic [1:0] ActTouch   = 2'd1;
    localparam logic [1:0] ActDelete  = 2'd2;
    localparam logic [1:0] ActEnforce = 2'd3;

    localparam logic KindEvict = 1'b0;
    localparam logic KindDone  = 1'b1;

    typedef struct packed {
        logic [1:0]       action;
        logic [KeyW-1:0]  key;
        logic [SizeW-1:0] object_bytes;
    } t_cmd;

    typedef struct packed {
        logic             kind;
        logic [KeyW-1:0]  victim_key;
        logic [SizeW-1:0] victim_bytes;
        logic             hit;
        logic [TotalW-1:0] bytes_in_use;
        logic             last;
    } t_res;
endpackage

### rtl/core/bbl_ram.sv
module bbl_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/core/bbl_front.sv
module bbl_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  bbl_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_take,
    output bbl_pkg::t_cmd o_cmd
);
    localparam int unsigned D  = bbl_pkg::CmdQDepth;
    localparam int unsigned AW = $clog2(D);

    bbl_pkg::t_cmd r_q [D];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          wr, rd;

    assign full    = (r_cnt == (AW+1)'(D));
    assign o_valid = (r_cnt != '0);
    assign wr      = push && !full;
    assign rd      = i_take && o_valid;
    assign o_cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= (r_wp == AW'(D-1)) ? '0 : r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= (r_rp == AW'(D-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end
endmodule

### rtl/core/bbl_back.sv
module bbl_back #(
    parameter int unsigned TABLE_ENTRIES = bbl_pkg::TableEntriesDefault
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_take,
    input  bbl_pkg::t_cmd              i_cmd,
    input  logic [bbl_pkg::TotalW-1:0] i_limit,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output bbl_pkg::t_res              o_res
);
    localparam int unsigned IW = $clog2(TABLE_ENTRIES);
    localparam int unsigned KW = bbl_pkg::KeyW;
    localparam int unsigned SW = bbl_pkg::SizeW;
    localparam int unsigned TW = bbl_pkg::TotalW;
    localparam int unsigned PW = bbl_pkg::StampW;
    localparam int unsigned IWC = $clog2(TABLE_ENTRIES + 1);

    localparam logic [3:0] StIdle  = 4'd0;
    localparam logic [3:0] StScan  = 4'd1;
    localparam logic [3:0] StScanW = 4'd2;
    localparam logic [3:0] StAct   = 4'd3;
    localparam logic [3:0] StLruR  = 4'd4;
    localparam logic [3:0] StLru   = 4'd5;
    localparam logic [3:0] StLruW  = 4'd6;
    localparam logic [3:0] StEvR   = 4'd7;
    localparam logic [3:0] StEvOut = 4'd8;
    localparam logic [3:0] StEnf   = 4'd9;
    localparam logic [3:0] StDone  = 4'd10;
    localparam logic [3:0] StSubR  = 4'd11;
    localparam logic [3:0] StSub   = 4'd12;

    logic [3:0]               r_st;
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [PW-1:0]            r_ctr;
    logic [TW-1:0]            r_total;
    bbl_pkg::t_cmd            r_cmd;
    logic [IWC-1:0]           r_i;
    logic                     r_hit, r_hasfree, r_full_store;
    logic [IW-1:0]            r_idx, r_free, r_best;
    logic                     r_hasbest;
    logic [PW-1:0]            r_bstamp;
    logic                     r_ov;
    bbl_pkg::t_res            r_res;

    logic          we_k, we_b, we_s;
    logic [IW-1:0] waddr, raddr;
    logic [KW-1:0] wkey, rkey;
    logic [SW-1:0] wbytes, rbytes;
    logic [PW-1:0] wstamp, rstamp;
    logic [IW-1:0] r_prev;

    bbl_ram #(.WIDTH(KW), .DEPTH(TABLE_ENTRIES)) u_key (
        .i_clk(i_clk), .i_we(we_k), .i_waddr(waddr), .i_wdata(wkey),
        .i_raddr(raddr), .o_rdata(rkey));
    bbl_ram #(.WIDTH(SW), .DEPTH(TABLE_ENTRIES)) u_bytes (
        .i_clk(i_clk), .i_we(we_b), .i_waddr(waddr), .i_wdata(wbytes),
        .i_raddr(raddr), .o_rdata(rbytes));
    bbl_ram #(.WIDTH(PW), .DEPTH(TABLE_ENTRIES)) u_stamp (
        .i_clk(i_clk), .i_we(we_s), .i_waddr(waddr), .i_wdata(wstamp),
        .i_raddr(raddr), .o_rdata(rstamp));

    logic [PW-1:0] ctr_inc;
    logic [TW:0]   add_sum;
    logic [TW-1:0] sum_sat, sub_fl;
    logic          store_wr, touch_wr, last_scan;
    logic          over;

    assign ctr_inc  = r_ctr + 1'b1;
    assign add_sum  = {1'b0, r_total} + (TW+1)'(r_cmd.object_bytes);
    assign sum_sat  = add_sum[TW] ? '1 : add_sum[TW-1:0];
    assign sub_fl   = (r_total >= TW'(rbytes)) ? r_total - TW'(rbytes) : '0;
    assign over     = (i_limit != '0) && (r_total > i_limit);
    assign last_scan = (r_i == IWC'(TABLE_ENTRIES - 1));
    assign o_take   = (r_st == StIdle) && i_valid;
    assign o_res_valid = r_ov;
    assign o_res    = r_res;

    assign store_wr = (r_st == StAct) && (r_cmd.action == bbl_pkg::ActStore);
    assign touch_wr = (r_st == StAct) && (r_cmd.action == bbl_pkg::ActTouch) && r_hit;
    assign waddr  = r_idx;
    assign wkey   = r_cmd.key;
    assign wbytes = r_cmd.object_bytes;
    assign wstamp = ctr_inc;
    assign we_k   = store_wr;
    assign we_b   = store_wr;
    assign we_s   = store_wr || touch_wr;

    always_comb begin
        raddr = r_i[IW-1:0];
        if (r_st == StSubR || r_st == StEvR || r_st == StEvOut) begin
            raddr = (r_st == StSubR) ? r_idx : r_best;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= StIdle;
            r_valid <= '0;
            r_ctr <= '0;
            r_total <= '0;
            r_ov <= 1'b0;
        end else begin
            if (r_ov && i_res_ready) begin
                r_ov <= 1'b0;
            end
            case (r_st)
                StIdle: begin
                    if (i_valid) begin
                        r_cmd <= i_cmd;
                        r_hit <= 1'b0;
                        r_hasfree <= 1'b0;
                        r_full_store <= 1'b0;
                        r_i <= '0;
                        r_st <= (i_cmd.action == bbl_pkg::ActEnforce) ? StEnf : StScan;
                    end
                end
                StScan: begin
                    r_prev <= r_i[IW-1:0];
                    r_st <= StScanW;
                end
                StScanW: begin
                    if (r_valid[r_prev] && rkey == r_cmd.key && !r_hit) begin
                        r_hit <= 1'b1;
                        r_idx <= r_prev;
                    end
                    if (!r_valid[r_prev] && !r_hasfree) begin
                        r_hasfree <= 1'b1;
                        r_free <= r_prev;
                    end
                    if (last_scan) begin
                        r_st <= StAct;
                        if (r_cmd.action == bbl_pkg::ActStore && !r_hit &&
                            !(r_valid[r_prev] && rkey == r_cmd.key)) begin
                            if (r_hasfree || !r_valid[r_prev]) begin
                                r_idx <= r_hasfree ? r_free : r_prev;
                            end else begin
                                r_full_store <= 1'b1;
                                r_i <= '0;
                                r_hasbest <= 1'b0;
                                r_st <= StLruR;
                            end
                        end else if (r_cmd.action != bbl_pkg::ActTouch &&
                                     (r_hit || (r_valid[r_prev] && rkey == r_cmd.key))) begin
                            r_st <= StSubR;
                        end
                    end else begin
                        r_i <= r_i + 1'b1;
                        r_st <= StScan;
                    end
                end
                StSubR: r_st <= StSub;
                StSub: begin
                    r_total <= sub_fl;
                    if (r_cmd.action == bbl_pkg::ActDelete) begin
                        r_valid[r_idx] <= 1'b0;
                        r_st <= StDone;
                    end else begin
                        r_st <= StAct;
                    end
                end
                StAct: begin
                    if (r_cmd.action == bbl_pkg::ActStore) begin
                        r_valid[r_idx] <= 1'b1;
                        r_ctr <= ctr_inc;
                        r_total <= sum_sat;
                        r_st <= StEnf;
                    end else begin
                        if (touch_wr) begin
                            r_ctr <= ctr_inc;
                        end
                        r_st <= StDone;
                    end
                end
                StEnf: begin
                    if (over && r_valid != '0) begin
                        r_i <= '0;
                        r_hasbest <= 1'b0;
                        r_st <= StLruR;
                    end else begin
                        r_st <= StDone;
                    end
                end
                StLruR: begin
                    r_prev <= r_i[IW-1:0];
                    r_st <= StLru;
                end
                StLru: begin
                    if (r_valid[r_prev] && (!r_hasbest || rstamp < r_bstamp)) begin
                        r_hasbest <= 1'b1;
                        r_best <= r_prev;
                        r_bstamp <= rstamp;
                    end
                    r_st <= last_scan ? StEvR : StLruR;
                    r_i <= r_i + 1'b1;
                end
                StEvR: r_st <= StEvOut;
                StEvOut: begin
                    if (!r_ov) begin
                        r_valid[r_best] <= 1'b0;
                        r_total <= sub_fl;
                        r_res <= '{bbl_pkg::KindEvict, rkey, rbytes, r_hit, sub_fl, 1'b0};
                        r_ov <= 1'b1;
                        if (r_full_store) begin
                            r_full_store <= 1'b0;
                            r_idx <= r_best;
                            r_st <= StAct;
                        end else begin
                            r_st <= StEnf;
                        end
                    end
                end
                StDone: begin
                    if (!r_ov) begin
                        r_res <= '{bbl_pkg::KindDone, '0, '0, r_hit, r_total, 1'b1};
                        r_ov <= 1'b1;
                        r_st <= StIdle;
                    end
                end
                default: r_st <= StIdle;
            endcase
        end
    end
endmodule

### rtl/core/byte_budget_lru_table_top.sv
// The back end takes a command when idle, reads every entry's key in turn (N = TABLE_ENTRIES),
// then updates the entry and gives the done result; each eviction adds a scan of all N stamps
// for the oldest entry and a read of the victim. Enforce alone skips the key scan.
// A new command is taken only once the done result of the last one is out, as the scans share
// the single read port of the entry memories; a two-deep command queue decouples push from it.
// Reset (synchronous, active low) clears valid bits, stamp counter, total, limit.
module byte_budget_lru_table_top #(
    parameter int unsigned TABLE_ENTRIES = bbl_pkg::TableEntriesDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_action,
    input  logic [63:0] i_key,
    input  logic [31:0] i_object_bytes,
    output logic        empty,
    input  logic        pop,
    output logic        o_kind,
    output logic [63:0] o_victim_key,
    output logic [31:0] o_victim_bytes,
    output logic        o_hit,
    output logic [47:0] o_bytes_in_use,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [47:0] i_cfg_byte_limit
);
    bbl_pkg::t_cmd cmd_in, cmd_q;
    bbl_pkg::t_res res;
    logic          q_valid, q_take, res_valid;
    logic [47:0]   r_limit;

    assign cmd_in = '{i_action, i_key, i_object_bytes};
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= '0;
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_byte_limit;
        end
    end

    bbl_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_cmd(cmd_in),
        .o_valid(q_valid), .i_take(q_take), .o_cmd(cmd_q));

    bbl_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .o_take(q_take),
        .i_cmd(cmd_q), .i_limit(r_limit), .o_res_valid(res_valid),
        .i_res_ready(pop), .o_res(res));

    assign empty          = !res_valid;
    assign o_kind         = res.kind;
    assign o_victim_key   = res.victim_key;
    assign o_victim_bytes = res.victim_bytes;
    assign o_hit          = res.hit;
    assign o_bytes_in_use = res.bytes_in_use;
    assign o_last         = res.last;
endmodule

### rtl/core/bbl_checker.sv
`include "byte_budget_lru_table_top_macros.svh"
module bbl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic        o_kind,
    input logic [63:0] o_victim_key,
    input logic [31:0] o_victim_bytes,
    input logic        o_last
);
    `BBL_ASSERT_IMP(a_done_last, i_clk, i_rst_n, !empty && o_kind, o_last)
    `BBL_ASSERT_IMP(a_evict_not_last, i_clk, i_rst_n, !empty && !o_kind, !o_last)
    `BBL_ASSERT_IMP(a_done_zero, i_clk, i_rst_n, !empty && o_kind, o_victim_key == '0 && o_victim_bytes == '0)
    `BBL_ASSERT_NXT(a_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_victim_key))
endmodule

bind byte_budget_lru_table_top bbl_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .empty(empty), .pop(pop), .o_kind(o_kind),
    .o_victim_key(o_victim_key), .o_victim_bytes(o_victim_bytes), .o_last(o_last));

### verif/byte_budget_lru_table_checker.sv
module byte_budget_lru_table_checker #(
    parameter int unsigned ENTRIES = bbl_pkg::TableEntriesDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [1:0]  i_action,
    input  logic [63:0] i_key,
    input  logic [31:0] i_object_bytes,
    input  logic        empty,
    input  logic        pop,
    input  logic        o_kind,
    input  logic [63:0] o_victim_key,
    input  logic [31:0] o_victim_bytes,
    input  logic        o_hit,
    input  logic [47:0] o_bytes_in_use,
    input  logic        o_last,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [47:0] i_cfg_byte_limit,
    output int          fail_cnt,
    output int          pending,
    output int          result_cnt,
    output int          evict_cnt
);
    bit                         slot_used  [ENTRIES];
    logic [bbl_pkg::KeyW-1:0]   slot_key   [ENTRIES];
    logic [bbl_pkg::SizeW-1:0]  slot_bytes [ENTRIES];
    logic [bbl_pkg::StampW-1:0] slot_stamp [ENTRIES];
    logic [bbl_pkg::StampW-1:0] stamp_now;
    logic [bbl_pkg::TotalW-1:0] bytes_total;
    logic [bbl_pkg::TotalW-1:0] limit;
    bbl_pkg::t_res              expected_q[$];

    initial begin
        fail_cnt   = 0;
        pending    = 0;
        result_cnt = 0;
        evict_cnt  = 0;
    end

    function automatic int oldest_slot();
        int best;
        best = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (slot_used[i] && (best < 0 || slot_stamp[i] < slot_stamp[best])) begin
                best = i;
            end
        end
        return best;
    endfunction

    task automatic take_bytes(input logic [bbl_pkg::SizeW-1:0] amount);
        bytes_total = (bytes_total >= amount) ? bytes_total - amount : '0;
    endtask

    task automatic evict_oldest(input logic h, output bit ok);
        int            v;
        bbl_pkg::t_res r;
        v  = oldest_slot();
        ok = (v >= 0);
        if (ok) begin
            slot_used[v] = 1'b0;
            take_bytes(slot_bytes[v]);
            r = '{bbl_pkg::KindEvict, slot_key[v], slot_bytes[v], h, bytes_total, 1'b0};
            expected_q.insert(expected_q.size(), r);
            evict_cnt++;
        end
    endtask

    task automatic trim_to_limit(input logic h);
        bit ok;
        if (limit != 0) begin
            while (bytes_total > limit) begin
                evict_oldest(h, ok);
                if (!ok) break;
            end
        end
    endtask

    task automatic predict_cmd(input logic [1:0] act, input logic [bbl_pkg::KeyW-1:0] k,
                               input logic [bbl_pkg::SizeW-1:0] sz);
        int                         idx;
        logic                       h;
        bit                         ok;
        logic [bbl_pkg::TotalW:0]   sum;
        bbl_pkg::t_res              r;
        idx = -1;
        if (act != bbl_pkg::ActEnforce) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (idx < 0 && slot_used[i] && slot_key[i] == k) idx = i;
            end
        end
        h = (idx >= 0);
        case (act)
            bbl_pkg::ActStore: begin
                if (idx >= 0) begin
                    take_bytes(slot_bytes[idx]);
                end else begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (idx < 0 && !slot_used[i]) idx = i;
                    end
                    if (idx < 0) begin
                        idx = oldest_slot();
                        evict_oldest(h, ok);
                    end
                end
                slot_used[idx]  = 1'b1;
                slot_key[idx]   = k;
                slot_bytes[idx] = sz;
                stamp_now       = stamp_now + 1;
                slot_stamp[idx] = stamp_now;
                sum = {1'b0, bytes_total} + sz;
                bytes_total = sum[bbl_pkg::TotalW] ? '1 : sum[bbl_pkg::TotalW-1:0];
                trim_to_limit(h);
            end
            bbl_pkg::ActTouch: begin
                if (idx >= 0) begin
                    stamp_now       = stamp_now + 1;
                    slot_stamp[idx] = stamp_now;
                end
            end
            bbl_pkg::ActDelete: begin
                if (idx >= 0) begin
                    take_bytes(slot_bytes[idx]);
                    slot_used[idx] = 1'b0;
                end
            end
            default: begin
                trim_to_limit(h);
            end
        endcase
        r = '{bbl_pkg::KindDone, '0, '0, h, bytes_total, 1'b1};
        expected_q.insert(expected_q.size(), r);
    endtask

    always @(posedge i_clk) begin
        bbl_pkg::t_res e;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) slot_used[i] = 1'b0;
            stamp_now   = '0;
            bytes_total = '0;
            limit       = '0;
            expected_q.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) limit = i_cfg_byte_limit;
            if (pop && !empty) begin
                result_cnt++;
                if (expected_q.size() == 0) begin
                    $error("unexpected result transfer");
                    fail_cnt++;
                end else begin
                    e = expected_q.pop_front();
                    if (o_kind !== e.kind) begin
                        $error("kind: expected %0h, got %0h", e.kind, o_kind);
                        fail_cnt++;
                    end
                    if (o_victim_key !== e.victim_key) begin
                        $error("victim_key: expected %0h, got %0h", e.victim_key, o_victim_key);
                        fail_cnt++;
                    end
                    if (o_victim_bytes !== e.victim_bytes) begin
                        $error("victim_bytes: expected %0h, got %0h",
                               e.victim_bytes, o_victim_bytes);
                        fail_cnt++;
                    end
                    if (o_hit !== e.hit) begin
                        $error("hit: expected %0h, got %0h", e.hit, o_hit);
                        fail_cnt++;
                    end
                    if (o_bytes_in_use !== e.bytes_in_use) begin
                        $error("bytes_in_use: expected %0h, got %0h",
                               e.bytes_in_use, o_bytes_in_use);
                        fail_cnt++;
                    end
                    if (o_last !== e.last) begin
                        $error("last: expected %0h, got %0h", e.last, o_last);
                        fail_cnt++;
                    end
                end
            end
            if (push && !full) predict_cmd(i_action, i_key, i_object_bytes);
        end
        pending = expected_q.size();
    end
endmodule

### verif/tb_byte_budget_lru_table_top.sv
module tb_byte_budget_lru_table_top;
    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [1:0]  i_action;
    logic [63:0] i_key;
    logic [31:0] i_object_bytes;
    logic        empty;
    logic        pop;
    logic        o_kind;
    logic [63:0] o_victim_key;
    logic [31:0] o_victim_bytes;
    logic        o_hit;
    logic [47:0] o_bytes_in_use;
    logic        o_last;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [47:0] i_cfg_byte_limit;

    int          fail_cnt;
    int          pending;
    int          result_cnt;
    int          evict_cnt;
    int          cmd_cnt;
    int          limit_cnt;
    bit          calm;
    logic [63:0] key_pool[40];

    byte_budget_lru_table_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_action         (i_action),
        .i_key            (i_key),
        .i_object_bytes   (i_object_bytes),
        .empty            (empty),
        .pop              (pop),
        .o_kind           (o_kind),
        .o_victim_key     (o_victim_key),
        .o_victim_bytes   (o_victim_bytes),
        .o_hit            (o_hit),
        .o_bytes_in_use   (o_bytes_in_use),
        .o_last           (o_last),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_byte_limit (i_cfg_byte_limit)
    );

    byte_budget_lru_table_checker checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_action         (i_action),
        .i_key            (i_key),
        .i_object_bytes   (i_object_bytes),
        .empty            (empty),
        .pop              (pop),
        .o_kind           (o_kind),
        .o_victim_key     (o_victim_key),
        .o_victim_bytes   (o_victim_bytes),
        .o_hit            (o_hit),
        .o_bytes_in_use   (o_bytes_in_use),
        .o_last           (o_last),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_byte_limit (i_cfg_byte_limit),
        .fail_cnt         (fail_cnt),
        .pending          (pending),
        .result_cnt       (result_cnt),
        .evict_cnt        (evict_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(4 * 10_000_000);
        $display("CHECK FAILED");
        $finish;
    end

    // result side
    initial begin
        int n;
        pop = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            n = calm ? 0 : $urandom_range(0, 3);
            if (n > 0) begin
                pop <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
        end
    end

    task automatic send_cmd(input logic [1:0] act, input logic [63:0] k,
                            input logic [31:0] sz);
        int n;
        n = calm ? 0 : $urandom_range(0, 3);
        if (n > 0) begin
            push <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        push           <= 1'b1;
        i_action       <= act;
        i_key          <= k;
        i_object_bytes <= sz;
        do @(posedge i_clk); while (full);
        cmd_cnt++;
    endtask

    task automatic drain();
        push <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [47:0] lim);
        i_cfg_valid      <= 1'b1;
        i_cfg_byte_limit <= lim;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        limit_cnt++;
    endtask

    task automatic random_cmds(input int count, input logic [31:0] scale);
        int          r;
        logic [1:0]  act;
        logic [63:0] k;
        logic [31:0] sz;
        for (int i = 0; i < count; i++) begin
            r   = $urandom_range(0, 99);
            act = (r < 50) ? bbl_pkg::ActStore : (r < 70) ? bbl_pkg::ActTouch :
                  (r < 85) ? bbl_pkg::ActDelete : bbl_pkg::ActEnforce;
            k   = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                              : key_pool[$urandom_range(0, 39)];
            r   = $urandom_range(0, 19);
            sz  = (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF : (r == 2) ? $urandom
                                   : $urandom_range(0, scale);
            send_cmd(act, k, sz);
        end
    endtask

    task automatic phase(input logic [47:0] lim, input int count, input logic [31:0] scale);
        drain();
        write_limit(lim);
        send_cmd(bbl_pkg::ActEnforce, {$urandom, $urandom}, $urandom);
        random_cmds(count, scale);
    endtask

    initial begin
        cmd_cnt          = 0;
        limit_cnt        = 0;
        calm             = 1'b0;
        i_rst_n          = 1'b0;
        push             = 1'b0;
        i_action         = bbl_pkg::ActStore;
        i_key            = '0;
        i_object_bytes   = '0;
        i_cfg_valid      = 1'b0;
        i_cfg_byte_limit = '0;
        for (int i = 0; i < 40; i++) key_pool[i] = {$urandom, $urandom};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_limit('0);
        send_cmd(bbl_pkg::ActTouch,   64'd0, 32'd0);
        send_cmd(bbl_pkg::ActDelete,  '1,    32'd0);
        send_cmd(bbl_pkg::ActEnforce, '1,    '1);
        send_cmd(bbl_pkg::ActStore,   64'd0, 32'd0);
        send_cmd(bbl_pkg::ActStore,   '1,    '1);
        send_cmd(bbl_pkg::ActStore,   '1,    32'd1);
        send_cmd(bbl_pkg::ActStore,   64'h5555_5555_5555_5555, '1);
        send_cmd(bbl_pkg::ActTouch,   64'd0, 32'd5);
        send_cmd(bbl_pkg::ActTouch,   '1,    32'd0);
        send_cmd(bbl_pkg::ActDelete,  64'd0, 32'd0);
        send_cmd(bbl_pkg::ActDelete,  64'd0, 32'd0);
        send_cmd(bbl_pkg::ActStore,   key_pool[0], 32'd7);
        send_cmd(bbl_pkg::ActEnforce, 64'd0, 32'd0);
        // overfill the table so stores push out the oldest entry
        for (int i = 0; i < 36; i++) send_cmd(bbl_pkg::ActStore, key_pool[i], 32'd100 + i);

        phase(48'd5000, 100, 32'd1500);
        phase('1, 60, '1);
        phase(48'd1, 60, 32'd4);
        calm = 1'b1;
        phase(48'($urandom_range(2000, 20000)), 100, 32'd3000);
        calm = 1'b0;
        phase('0, 86, 32'd2000);
        drain();

        $display("Sent %0d commands over %0d byte limits; checked %0d results, %0d evictions.",
                 cmd_cnt, limit_cnt, result_cnt, evict_cnt);
        if (fail_cnt == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

### files.f
+incdir+rtl/core
rtl/core/bbl_pkg.sv
rtl/core/bbl_ram.sv
rtl/core/bbl_front.sv
rtl/core/bbl_back.sv
rtl/core/byte_budget_lru_table_top.sv
rtl/core/bbl_checker.sv
verif/byte_budget_lru_table_checker.sv
verif/tb_byte_budget_lru_table_top.sv
